// ===== src/fraction_reduce_macros.svh =====
// ----------------------------------------------------------------------------
// fraction_reduce_macros.svh
// Assertion macros shared by the fraction reduction RTL. They compile to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FRACTION_REDUCE_MACROS_SVH
`define FRACTION_REDUCE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge out of reset
`define FRD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fraction_reduce: assertion failed");

// Next-cycle implication
`define FRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fraction_reduce: assertion failed");

`else

`define FRD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FRD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/frd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frd_pkg
// Widths, controller states and the command/status bundles that join the
// fraction reduction controller and datapath.
// ----------------------------------------------------------------------------
package frd_pkg;

    localparam int DATA_WIDTH = 32;
    // magnitude width: the most negative input is saturated away
    localparam int MAG_W      = DATA_WIDTH - 1;
    localparam int K_W        = $clog2(MAG_W);
    localparam int CNT_W      = $clog2(MAG_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD,
        S_DIV_TOP,
        S_DIV_BOT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;       // capture an input word
        logic gcd_step;   // one binary GCD step
        logic div_init;   // latch the divisor, start on the numerator
        logic div_step;   // one restoring division step
        logic save_top;   // keep numerator quotient, start on denominator
        logic save_bot;   // keep denominator quotient
        logic out_load;   // move the result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic bad;        // denominator was zero
        logic gcd_done;   // one GCD operand reached zero
        logic div_last;   // final division step this cycle
        logic out_free;   // output register can take a word
    } t_dp_status;

endpackage

// ===== src/frd_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frd_in_if
// Input channel: one fraction word, numerator and denominator.
// ----------------------------------------------------------------------------
interface frd_in_if
    import frd_pkg::*;
;
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] top_value;
    logic signed [DATA_WIDTH-1:0] bottom_value;

    modport source (output valid, output top_value, output bottom_value, input ready);
    modport sink   (input valid, input top_value, input bottom_value, output ready);
endinterface

// ===== src/frd_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frd_out_if
// Output channel: one reduced fraction word plus the zero-denominator flag.
// ----------------------------------------------------------------------------
interface frd_out_if
    import frd_pkg::*;
;
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] reduced_top;
    logic        [MAG_W-1:0]      reduced_bottom;
    logic                         bad_bottom;

    modport source (output valid, output reduced_top, output reduced_bottom,
                    output bad_bottom, input ready);
    modport sink   (input valid, input reduced_top, input reduced_bottom,
                    input bad_bottom, output ready);
endinterface

// ===== src/fraction_reduce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_reduce
// Reduces a signed fraction to lowest terms: both magnitudes divided by
// their GCD, sign on the numerator, denominator positive, 0/1 for a zero
// numerator, 0/1 with bad_bottom set for a zero denominator.
//
//  channel  | dir | word
//  ---------+-----+------------------------------------------------
//  i_in     | in  | top_value[31:0] s, bottom_value[31:0] s
//  o_out    | out | reduced_top[31:0] s, reduced_bottom[30:0], bad_bottom
//
// One word at a time: an accept, binary GCD steps, a divisor latch,
// restoring division steps for the numerator and then the denominator
// (one shared divider) and a hand-off; a zero denominator skips the GCD
// and the divisions. The output register lets the next word be accepted
// while a result waits. Reset (synchronous, active low) clears the
// sequencer and the output valid flag; no clearing pass.
// ----------------------------------------------------------------------------
module fraction_reduce
    import frd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    frd_in_if.sink    i_in,
    frd_out_if.source o_out
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    frd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    frd_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_top_value    (i_in.top_value),
        .i_bottom_value (i_in.bottom_value),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_out          (o_out)
    );

endmodule

// ===== src/frd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frd_ctrl
// Sequencer: accept, binary GCD, two restoring divisions, hand-off to the
// output register.
// ----------------------------------------------------------------------------
module frd_ctrl
    import frd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_GCD;
            end
            S_GCD: begin
                if (i_status.bad)           n_state = S_DONE;
                else if (i_status.gcd_done) n_state = S_DIV_TOP;
            end
            S_DIV_TOP: begin
                if (i_status.div_last) n_state = S_DIV_BOT;
            end
            S_DIV_BOT: begin
                if (i_status.div_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_GCD: begin
                if (!i_status.bad) begin
                    o_cmd.gcd_step = !i_status.gcd_done;
                    o_cmd.div_init = i_status.gcd_done;
                end
            end
            S_DIV_TOP: begin
                o_cmd.div_step = 1'b1;
                o_cmd.save_top = i_status.div_last;
            end
            S_DIV_BOT: begin
                o_cmd.div_step = 1'b1;
                o_cmd.save_bot = i_status.div_last;
            end
            S_DONE: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== src/frd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frd_datapath
// Sign split, binary GCD unit, shared restoring divider and the output
// register.
// ----------------------------------------------------------------------------
`include "fraction_reduce_macros.svh"

module frd_datapath
    import frd_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic signed [DATA_WIDTH-1:0] i_top_value,
    input  logic signed [DATA_WIDTH-1:0] i_bottom_value,
    input  t_dp_cmd                      i_cmd,
    output t_dp_status                   o_status,
    frd_out_if.source                    o_out
);

    // saturated magnitude of a two's complement word
    function automatic logic [MAG_W-1:0] mag_of(input logic [DATA_WIDTH-1:0] v);
        logic [DATA_WIDTH-1:0] neg;
        neg = DATA_WIDTH'(0) - v;
        if (!v[DATA_WIDTH-1])       mag_of = v[MAG_W-1:0];
        else if (neg[DATA_WIDTH-1]) mag_of = {MAG_W{1'b1}};
        else                        mag_of = neg[MAG_W-1:0];
    endfunction

    logic [MAG_W-1:0]      r_top_mag;
    logic [MAG_W-1:0]      r_bot_mag;
    logic                  r_neg;
    logic                  r_bad;
    logic [MAG_W-1:0]      r_a;
    logic [MAG_W-1:0]      r_b;
    logic [K_W-1:0]        r_k;
    logic [MAG_W-1:0]      r_g;
    logic [MAG_W-1:0]      r_rem;
    logic [MAG_W-1:0]      r_q;
    logic [CNT_W-1:0]      r_cnt;
    logic [MAG_W-1:0]      r_n;
    logic [MAG_W-1:0]      r_d;
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_out_top;
    logic [MAG_W-1:0]      r_out_bot;
    logic                  r_out_bad;

    logic [MAG_W:0]        w_diff_ab;
    logic [MAG_W:0]        w_diff_ba;
    logic [MAG_W:0]        w_trial;
    logic [MAG_W-1:0]      w_rem_step;
    logic [MAG_W-1:0]      w_q_step;
    logic [DATA_WIDTH-1:0] w_n_ext;
    logic                  w_gcd_done;

    // GCD compare/subtract
    assign w_diff_ab  = {1'b0, r_a} - {1'b0, r_b};
    assign w_diff_ba  = {1'b0, r_b} - {1'b0, r_a};
    assign w_gcd_done = (r_a == '0) || (r_b == '0);

    // restoring division step
    assign w_trial    = {r_rem, r_q[MAG_W-1]} - {1'b0, r_g};
    assign w_rem_step = w_trial[MAG_W] ? {r_rem[MAG_W-2:0], r_q[MAG_W-1]} : w_trial[MAG_W-1:0];
    assign w_q_step   = {r_q[MAG_W-2:0], !w_trial[MAG_W]};

    assign w_n_ext = {1'b0, r_n};

    // status to the controller
    always_comb begin
        o_status.bad      = r_bad;
        o_status.gcd_done = w_gcd_done;
        o_status.div_last = (r_cnt == CNT_W'(MAG_W - 1));
        o_status.out_free = !r_out_valid || o_out.ready;
    end

    // input capture and binary GCD
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_top_mag <= mag_of(i_top_value);
            r_bot_mag <= mag_of(i_bottom_value);
            r_a       <= mag_of(i_top_value);
            r_b       <= mag_of(i_bottom_value);
            r_neg     <= i_top_value[DATA_WIDTH-1] ^ i_bottom_value[DATA_WIDTH-1];
            r_bad     <= (i_bottom_value == '0);
            r_k       <= '0;
        end else if (i_cmd.gcd_step) begin
            if (!r_a[0] && !r_b[0]) begin
                r_a <= r_a >> 1;
                r_b <= r_b >> 1;
                r_k <= r_k + K_W'(1);
            end else if (!r_a[0]) begin
                r_a <= r_a >> 1;
            end else if (!r_b[0]) begin
                r_b <= r_b >> 1;
            end else if (!w_diff_ab[MAG_W]) begin
                r_a <= w_diff_ab[MAG_W:1];
            end else begin
                r_b <= w_diff_ba[MAG_W:1];
            end
        end
    end

    // shared divider: numerator first, then denominator
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_g   <= (r_a | r_b) << r_k;
            r_rem <= '0;
            r_q   <= r_top_mag;
            r_cnt <= '0;
        end else if (i_cmd.save_top) begin
            r_n   <= w_q_step;
            r_rem <= '0;
            r_q   <= r_bot_mag;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_rem_step;
            r_q   <= w_q_step;
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.save_bot) begin
            r_d <= w_q_step;
        end
    end

    // output register, valid flag is control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_bad <= r_bad;
            if (r_bad) begin
                r_out_top <= '0;
                r_out_bot <= MAG_W'(1);
            end else begin
                r_out_top <= r_neg ? (DATA_WIDTH'(0) - w_n_ext) : w_n_ext;
                r_out_bot <= r_d;
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.reduced_top    = r_out_top;
    assign o_out.reduced_bottom = r_out_bot;
    assign o_out.bad_bottom     = r_out_bad;

    // checks
    `FRD_ASSERT_NOW(a_gcd_step_live, i_clk, i_rst_n, i_cmd.gcd_step, !w_gcd_done)
    `FRD_ASSERT_NOW(a_bot_nonzero, i_clk, i_rst_n, r_out_valid, r_out_bot != '0)
    `FRD_ASSERT_NOW(a_bad_is_zero_over_one, i_clk, i_rst_n, r_out_valid && r_out_bad,
                    (r_out_top == '0) && (r_out_bot == MAG_W'(1)))
    `FRD_ASSERT_NEXT(a_load_fills_output, i_clk, i_rst_n, i_cmd.out_load, r_out_valid)

endmodule

// ===== test/fraction_reduce_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_reduce_tb
// Self-checking bench for the fraction reducer. A short list of corner
// fractions is followed by random words: full-range values, pairs with a
// large shared factor, zero sides, small values and the range ends. Every
// accepted input word is reduced by Euclid's method inside the bench. Each
// output word is compared field by field with the oldest expected fraction.
// Both channels idle at random in two phases. One burst runs while the
// output is held off for a long stretch, and a drain follows each phase.
// ----------------------------------------------------------------------------
module fraction_reduce_tb
    import frd_pkg::*;
;

    localparam logic signed [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {MAG_W{1'b0}}};
    localparam logic signed [DATA_WIDTH-1:0] MOST_POS = {1'b0, {MAG_W{1'b1}}};
    localparam int STALL_LIMIT = 4000;   // cycles with no word moving on either side
    localparam int HOLD_CYCLES = 400;    // long output hold-off
    localparam int TAIL_CYCLES = 150;    // above the worst-case latency

    typedef struct {
        logic signed [DATA_WIDTH-1:0] top;
        logic        [MAG_W-1:0]      bottom;
        logic                         bad;
    } t_fraction;

    // Expected fractions in input order, and the reduction that makes them
    class reduced_fraction_board;
        t_fraction reduced_q[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        // Magnitude with the most negative word clamped to the largest positive
        function logic [MAG_W-1:0] clamped_mag(logic signed [DATA_WIDTH-1:0] v);
            logic [DATA_WIDTH-1:0] m;
            m = v[DATA_WIDTH-1] ? -v : v;
            if (m[DATA_WIDTH-1])
                return {MAG_W{1'b1}};
            return m[MAG_W-1:0];
        endfunction

        function t_fraction reduce_fraction(logic signed [DATA_WIDTH-1:0] num,
                                            logic signed [DATA_WIDTH-1:0] den);
            t_fraction        f;
            logic [MAG_W-1:0] num_mag, den_mag, a, b, r;
            num_mag = clamped_mag(num);
            den_mag = clamped_mag(den);
            f.top    = '0;
            f.bottom = MAG_W'(1);
            f.bad    = (den_mag == 0);
            if (den_mag == 0 || num_mag == 0)
                return f;
            // Euclid
            a = num_mag;
            b = den_mag;
            while (b != 0) begin
                r = a % b;
                a = b;
                b = r;
            end
            f.top    = {1'b0, num_mag / a};
            f.bottom = den_mag / a;
            // sign of the fraction lands on the numerator
            if (num[DATA_WIDTH-1] != den[DATA_WIDTH-1])
                f.top = -f.top;
            return f;
        endfunction

        function void note_input(logic signed [DATA_WIDTH-1:0] num,
                                 logic signed [DATA_WIDTH-1:0] den);
            reduced_q.push_back(reduce_fraction(num, den));
        endfunction

        function void check_result(t_fraction got);
            t_fraction want;
            if (reduced_q.size() == 0) begin
                $error("unexpected word: top %0d bottom %0d bad %0b",
                       got.top, got.bottom, got.bad);
                errors++;
                return;
            end
            want = reduced_q.pop_front();
            if (got.top !== want.top) begin
                $error("reduced_top: expected %0d, got %0d", want.top, got.top);
                errors++;
            end
            if (got.bottom !== want.bottom) begin
                $error("reduced_bottom: expected %0d, got %0d", want.bottom, got.bottom);
                errors++;
            end
            if (got.bad !== want.bad) begin
                $error("bad_bottom: expected %0b, got %0b", want.bad, got.bad);
                errors++;
            end
        endfunction

        function int pending_count();
            return reduced_q.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    frd_in_if  in_ch();
    frd_out_if out_ch();

    fraction_reduce dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    reduced_fraction_board board;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Offer one word, with random idle cycles first; returns once accepted
    task automatic send_fraction(input logic signed [DATA_WIDTH-1:0] num,
                                 input logic signed [DATA_WIDTH-1:0] den);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid        <= 1'b1;
        in_ch.top_value    <= num;
        in_ch.bottom_value <= den;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        board.note_input(num, den);
    endtask

    // Stop offering and wait for every expected word
    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (board.pending_count() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_random(input int count);
        logic signed [DATA_WIDTH-1:0] num, den;
        int unsigned                  factor;
        logic signed [DATA_WIDTH-1:0] corner_vals[6] = '{MOST_NEG, -MOST_POS, MOST_POS,
                                                         1, -1, 0};
        repeat (count) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    num = $urandom;
                    den = $urandom;
                end
                4, 5, 6: begin
                    // shared factor up to 16 bits keeps the GCD nontrivial
                    factor = $urandom_range(1, 65535);
                    num = factor * $urandom_range(0, 32767);
                    den = factor * $urandom_range(1, 32767);
                    if ($urandom_range(0, 1)) num = -num;
                    if ($urandom_range(0, 1)) den = -den;
                end
                7: begin
                    num = $urandom;
                    den = $urandom;
                    if ($urandom_range(0, 1)) den = '0;
                    else num = '0;
                end
                8: begin
                    num = int'($urandom_range(0, 40)) - 20;
                    den = int'($urandom_range(0, 40)) - 20;
                end
                default: begin
                    num = corner_vals[$urandom_range(0, 5)];
                    den = corner_vals[$urandom_range(0, 5)];
                end
            endcase
            send_fraction(num, den);
        end
    endtask

    // Output side: long hold-off when asked, else random stalls
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Sample output words at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            board.check_result(t_fraction'{out_ch.reduced_top, out_ch.reduced_bottom,
                                           out_ch.bad_bottom});
    end

    // Watchdog on cycles where no word moves
    initial begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall = 0;
            else
                stall++;
        end
        $display("fraction_reduce_tb: errors");
        $finish;
    end

    initial begin
        board              = new();
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.top_value    = '0;
        in_ch.bottom_value = '0;
        hold_left          = 0;
        send_idle_pct      = 9;
        recv_idle_pct      = 70;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Corners: zero sides, range ends, clamped minimum, every sign pairing
        send_fraction(0, 0);
        send_fraction(5, 0);
        send_fraction(MOST_NEG, 0);
        send_fraction(0, 7);
        send_fraction(0, -7);
        send_fraction(0, MOST_NEG);
        send_fraction(MOST_POS, MOST_POS);
        send_fraction(MOST_POS, -MOST_POS);
        send_fraction(-MOST_POS, -MOST_POS);
        send_fraction(MOST_NEG, 1);
        send_fraction(1, MOST_NEG);
        send_fraction(MOST_NEG, MOST_NEG);
        send_fraction(MOST_NEG, MOST_POS);
        send_fraction(6, 4);
        send_fraction(-6, 4);
        send_fraction(6, -4);
        send_fraction(-6, -4);
        send_fraction(1, 1);
        send_fraction(MOST_POS, 1);
        send_fraction(-1, MOST_POS);
        send_fraction(32'sh4000_0000, 32'sh2000_0000);
        send_fraction(-32'sh4000_0000, 3);
        send_fraction(1836311903, 1134903170);
        send_fraction(-1836311903, -1134903170);

        run_random(270);
        drain_results();

        send_idle_pct = 70;
        recv_idle_pct = 9;
        run_random(270);
        drain_results();

        // Output held off while words keep coming, then a full drain
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = HOLD_CYCLES;
        run_random(12);
        drain_results();

        run_random(250);
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (board.errors == 0 && board.pending_count() == 0)
            $display("fraction_reduce_tb: clean");
        else
            $display("fraction_reduce_tb: errors");
        $finish;
    end

endmodule
